// ----- hdl/rapq_pkg.sv -----
package rapq_pkg;

  localparam int LEAVES_DEF = 1024;
  localparam int POS_W      = 10;
  localparam int ADDEND_W   = 32;
  localparam int VALUE_W    = 64;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic load;
    logic clr_wr;
    logic rd_a;
    logic wr_a;
    logic rd_b;
    logic wr_b;
    logic shift;
    logic q_read;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic range_done;
    logic a_odd;
    logic b_odd;
    logic n_zero;
  } dp_status_t;

endpackage

// ----- hdl/rapq_datapath.sv -----
module rapq_datapath #(
  parameter int LEAVES = rapq_pkg::LEAVES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  rapq_pkg::dp_cmd_t                      cmd,
  output rapq_pkg::dp_status_t                   status,
  input  logic [rapq_pkg::POS_W-1:0]             range_low,
  input  logic [rapq_pkg::POS_W-1:0]             range_high,
  input  logic signed [rapq_pkg::ADDEND_W-1:0]   addend,
  input  logic [rapq_pkg::POS_W-1:0]             point_index,
  output logic signed [rapq_pkg::VALUE_W-1:0]    point_value
);
  import rapq_pkg::*;

  localparam int NODES  = 2 * LEAVES;
  localparam int NODE_W = $clog2(NODES);
  localparam int BW     = NODE_W + 1;
  localparam int PW     = ((NODE_W > POS_W) ? NODE_W : POS_W) + 2;
  localparam logic [PW-1:0]     LEAVES_P  = PW'(LEAVES);
  localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

  logic [VALUE_W-1:0] mem [0:NODES-1];
  logic [VALUE_W-1:0] rdata;
  logic [VALUE_W-1:0] sum;
  logic [VALUE_W-1:0] amount;
  logic [VALUE_W-1:0] wdata;
  logic [BW-1:0]      a;
  logic [BW-1:0]      b;
  logic [BW-1:0]      a_next;
  logic [BW-1:0]      b_next;
  logic [BW-1:0]      bm1;
  logic [BW-1:0]      a_load;
  logic [BW-1:0]      b_load;
  logic [NODE_W-1:0]  n;
  logic [NODE_W-1:0]  n_load;
  logic [NODE_W-1:0]  clr_addr;
  logic [NODE_W-1:0]  raddr;
  logic [NODE_W-1:0]  waddr;
  logic [PW-1:0]      lo_x;
  logic [PW-1:0]      hi_x;
  logic [PW-1:0]      hi_c;
  logic [PW-1:0]      pos_x;
  logic               empty;
  logic               we;
  logic               pend;

  // A range past the last leaf is clipped; an empty range loads a == b.
  always_comb begin
    lo_x   = PW'(range_low);
    hi_x   = PW'(range_high);
    pos_x  = PW'(point_index);
    hi_c   = (hi_x >= LEAVES_P) ? (LEAVES_P - PW'(1)) : hi_x;
    empty  = (lo_x >= LEAVES_P) || (lo_x > hi_c);
    a_load = empty ? '0 : BW'(lo_x + LEAVES_P);
    b_load = empty ? '0 : BW'(hi_c + LEAVES_P + PW'(1));
    n_load = (pos_x >= LEAVES_P) ? '0 : NODE_W'(pos_x + LEAVES_P);
  end

  always_comb begin
    bm1    = b - BW'(1);
    a_next = a;
    b_next = b;
    if (cmd.load) begin
      a_next = a_load;
      b_next = b_load;
    end else begin
      if (cmd.wr_a) begin
        a_next = a + BW'(1);
      end
      if (cmd.wr_b) begin
        b_next = bm1;
      end
      if (cmd.shift) begin
        a_next = a_next >> 1;
        b_next = b_next >> 1;
      end
    end
  end

  always_comb begin
    if (cmd.rd_b) begin
      raddr = bm1[NODE_W-1:0];
    end else if (cmd.rd_a) begin
      raddr = a[NODE_W-1:0];
    end else begin
      raddr = n;
    end
    we = cmd.clr_wr | cmd.wr_a | cmd.wr_b;
    if (cmd.clr_wr) begin
      waddr = clr_addr;
      wdata = '0;
    end else begin
      waddr = cmd.wr_b ? bm1[NODE_W-1:0] : a[NODE_W-1:0];
      wdata = rdata + amount;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    a <= a_next;
    b <= b_next;
    if (cmd.load) begin
      amount <= VALUE_W'(addend);
      n      <= n_load;
      sum    <= '0;
    end else begin
      if (cmd.q_read) begin
        n <= n >> 1;
      end
      if (pend) begin
        sum <= sum + rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      pend     <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + NODE_W'(1);
      end
      pend <= cmd.q_read;
    end
  end

  always_comb begin
    status.clr_last   = (clr_addr == LAST_NODE);
    status.range_done = (a >= b);
    status.a_odd      = a[0];
    status.b_odd      = b[0];
    status.n_zero     = (n == '0);
  end

  assign point_value = $signed(sum);

endmodule

// ----- hdl/rapq_ctrl.sv -----
module rapq_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 command,
  input  rapq_pkg::dp_status_t status,
  output rapq_pkg::dp_cmd_t    cmd,
  output logic                 busy,
  output logic                 done
);
  import rapq_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LVL   = 3'd2;
  localparam logic [2:0] S_AWR   = 3'd3;
  localparam logic [2:0] S_BWR   = 3'd4;
  localparam logic [2:0] S_QWALK = 3'd5;
  localparam logic [2:0] S_QDONE = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = (command == CMD_QUERY) ? S_QWALK : S_LVL;
        end
      end
      S_LVL: begin
        if (status.range_done) begin
          state_next = S_IDLE;
        end else if (status.a_odd) begin
          cmd.rd_a   = 1'b1;
          state_next = S_AWR;
        end else if (status.b_odd) begin
          cmd.rd_b   = 1'b1;
          state_next = S_BWR;
        end else begin
          cmd.shift  = 1'b1;
        end
      end
      S_AWR: begin
        cmd.wr_a = 1'b1;
        if (status.b_odd) begin
          cmd.rd_b   = 1'b1;
          state_next = S_BWR;
        end else begin
          cmd.shift  = 1'b1;
          state_next = S_LVL;
        end
      end
      S_BWR: begin
        cmd.wr_b   = 1'b1;
        cmd.shift  = 1'b1;
        state_next = S_LVL;
      end
      S_QWALK: begin
        if (status.n_zero) begin
          state_next = S_QDONE;
        end else begin
          cmd.q_read = 1'b1;
        end
      end
      S_QDONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_QDONE);

endmodule

// ----- hdl/range_add_point_query_tree_unit.sv -----
// Range add and point query over a segment tree of LEAVES positions.
// A command beat is taken at a rising edge where start is high and busy
// is low; command selects an add of addend over range_low..range_high or
// a query of point_index. Only a query gives a result: point_value is
// shown for exactly one cycle with done high, and the receiver cannot
// stall it, so it must take the beat in that cycle.
// The node sums sit in one memory with a write port and a registered read
// port, and each step of a command makes at most one read and one write.
// A query reads one node per tree level, from its leaf up to the root,
// adds each read into the sum and then shows the result; busy drops the
// cycle after done.
// An add walks up the tree level by level, and at each level does a node
// read-modify-write at the low end, the high end, both or neither.
// One command runs at a time.
// After reset the block clears all 2*LEAVES node sums, one per cycle, and
// holds busy high until all are cleared, before it takes a command.
module range_add_point_query_tree_unit #(
  parameter int LEAVES = rapq_pkg::LEAVES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [rapq_pkg::POS_W-1:0]           range_low,
  input  logic [rapq_pkg::POS_W-1:0]           range_high,
  input  logic signed [rapq_pkg::ADDEND_W-1:0] addend,
  input  logic [rapq_pkg::POS_W-1:0]           point_index,
  output logic                                 done,
  output logic signed [rapq_pkg::VALUE_W-1:0]  point_value
);
  import rapq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rapq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy),
    .done    (done)
  );

  rapq_datapath #(
    .LEAVES (LEAVES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .range_low   (range_low),
    .range_high  (range_high),
    .addend      (addend),
    .point_index (point_index),
    .point_value (point_value)
  );

endmodule

// ----- hdl/rapq_checker.sv -----
module rapq_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic command,
  input logic done
);
  import rapq_pkg::*;

  // The store is cleared after reset, so no beat is taken right away.
  a_busy_after_rst: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result beat while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> (!done && !busy))
    else $error("result strobe longer than one cycle or busy after it");

  a_add_no_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_ADD) |=> (busy && !done))
    else $error("add command gave a result beat or was not taken");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && command == CMD_QUERY) |=> (busy && !done))
    else $error("query command not taken");

endmodule

bind range_add_point_query_tree_unit rapq_checker u_rapq_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .command (command),
  .done    (done)
);
